[hw/rtl/lott_pkg.sv]
package lott_pkg;

   // default table depth
   localparam int ENTRIES_DEF = 64;

   localparam int ADDR_W = 32;
   localparam int TAG_W  = 16;

   // event codes
   localparam logic [1:0] MODE_CONSTRUCT = 2'd0;
   localparam logic [1:0] MODE_DESTRUCT  = 2'd1;
   localparam logic [1:0] MODE_REPORT    = 2'd2;

   // result codes
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_BAD_CONSTRUCT = 3'd1;
   localparam logic [2:0] ST_NO_SPACE      = 3'd2;
   localparam logic [2:0] ST_BAD_DESTROY   = 3'd3;
   localparam logic [2:0] ST_BAD_ADDRESS   = 3'd4;
   localparam logic [2:0] ST_LEAK          = 3'd5;
   localparam logic [2:0] ST_NO_LEAKS      = 3'd6;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] object_address;
      logic [TAG_W-1:0]  type_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ADDR_W-1:0] leak_address;
      logic [TAG_W-1:0]  leak_tag;
      logic              last;
   } rsp_type;

   // contents of one slot as handed along the chain
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [TAG_W-1:0]  tag;
      logic              pending;
   } slot_type;

   // per-cycle commands broadcast to every cell
   typedef struct packed {
      logic compare;    // latch match/free flags against the request
      logic commit;     // write or clear the picked slot
      logic construct;  // pick a free slot (else a matching one)
      logic load;       // mark occupied slots pending for a report
      logic rotate;     // take the neighbor's slot
   } cell_ctl_type;

endpackage

[hw/rtl/live_object_tracking_table_unit.sv]
// Live object tracking table.
// req_*: one word per event (construct, destruct, report), valid/ready.
// rsp_*: result words, valid/ready, from an output register. While the
//   receiver stalls, the current word holds, and the next table update or
//   leak word waits until that word is taken.
// Construct/destruct: all cells compare against the request in the compare
//   state; in the update state, once the output register is free, the
//   priority chain picks and writes the slot, the result loads, and a new
//   event can be taken in that same cycle.
// Report: the load state marks occupied slots, then the table rotates
//   through the chain one slot per cycle for ENTRIES steps, emitting a leak
//   word whenever the head cell is occupied (last set on the final one). The
//   next event is taken only after the last step; the rotation pauses while
//   a leak word waits. An empty table gives one no-leak word and no rotation.
// An unused mode code is taken and dropped without a result.
// Reset is synchronous: all slots become free, no word is pending.
module live_object_tracking_table_unit #(
   parameter int ENTRIES = lott_pkg::ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lott_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lott_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(ENTRIES);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMP  = 3'd1;
   localparam logic [2:0] S_UPD  = 3'd2;
   localparam logic [2:0] S_LOAD = 3'd3;
   localparam logic [2:0] S_RPT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   lott_pkg::req_type      req_ff, req_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   empty_ff, empty_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lott_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   lott_pkg::cell_ctl_type ctl;
   lott_pkg::slot_type     slots [ENTRIES];
   lott_pkg::slot_type     nb    [ENTRIES];
   logic [ENTRIES:0]       pick;
   logic [ENTRIES:0]       hit;

   logic out_free;
   logic accept;
   logic any_occ;
   logic any_pending;
   logic remaining;
   logic head_occ;
   logic is_construct;
   logic found;
   logic hit_any;
   logic step;
   logic upd_go;

   // row of cells, each takes its upper neighbor on rotate, the top cell takes cell 0
   assign pick[0] = 1'b0;
   assign hit[0]  = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == ENTRIES - 1) begin : g_wrap
         assign nb[i] = '{address: slots[0].address, tag: slots[0].tag, pending: 1'b0};
      end else begin : g_link
         assign nb[i] = slots[i+1];
      end
      lott_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .req_address (req_ff.object_address),
         .req_tag     (req_ff.type_tag),
         .nb_slot     (nb[i]),
         .slot        (slots[i]),
         .pick_in     (pick[i]),
         .pick_out    (pick[i+1]),
         .hit_in      (hit[i]),
         .hit_out     (hit[i+1])
      );
   end

   assign found   = pick[ENTRIES];
   assign hit_any = hit[ENTRIES];

   // table-wide flags
   always_comb begin
      any_occ     = 1'b0;
      any_pending = 1'b0;
      remaining   = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         any_occ     = any_occ | (slots[i].address != '0);
         any_pending = any_pending | slots[i].pending;
      end
      for (int i = 1; i < ENTRIES; i++) begin
         remaining = remaining | slots[i].pending;
      end
   end

   assign head_occ     = (slots[0].address != '0);
   assign is_construct = (req_ff.mode == lott_pkg::MODE_CONSTRUCT);
   assign out_free     = ~rsp_valid_ff | rsp_ready;
   assign upd_go       = (state_ff == S_UPD) && out_free;
   assign req_ready    = (state_ff == S_IDLE) || upd_go;
   assign accept       = req_valid & req_ready;
   assign step         = (state_ff == S_RPT) && ~empty_ff && (~head_occ || out_free);

   // cell commands
   always_comb begin
      ctl.compare   = (state_ff == S_CMP);
      ctl.construct = is_construct;
      ctl.commit    = upd_go && (req_ff.object_address != '0) && (~is_construct || ~hit_any);
      ctl.load      = (state_ff == S_LOAD);
      ctl.rotate    = step;
   end

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in          = '0;
               rsp_data_in.last     = 1'b1;
               if (req_ff.object_address == '0) begin
                  rsp_data_in.status = lott_pkg::ST_BAD_ADDRESS;
               end else if (is_construct) begin
                  if (hit_any) begin
                     rsp_data_in.status = lott_pkg::ST_BAD_CONSTRUCT;
                  end else if (!found) begin
                     rsp_data_in.status = lott_pkg::ST_NO_SPACE;
                  end else begin
                     rsp_data_in.status = lott_pkg::ST_OK;
                  end
               end else begin
                  rsp_data_in.status = found ? lott_pkg::ST_OK : lott_pkg::ST_BAD_DESTROY;
               end
               state_in = S_IDLE;
            end
         end
         S_LOAD: begin
            empty_in = ~any_occ;
            cnt_in   = '0;
            state_in = S_RPT;
         end
         S_RPT: begin
            if (empty_ff) begin
               if (out_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in         = '0;
                  rsp_data_in.status  = lott_pkg::ST_NO_LEAKS;
                  rsp_data_in.last    = 1'b1;
                  state_in            = S_IDLE;
               end
            end else if (step) begin
               if (head_occ) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.status       = lott_pkg::ST_LEAK;
                  rsp_data_in.leak_address = slots[0].address;
                  rsp_data_in.leak_tag     = slots[0].tag;
                  rsp_data_in.last         = ~remaining;
               end
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(ENTRIES - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
         end
      endcase

      // new event, taken in idle or as an update finishes
      if (accept) begin
         req_in = req_data;
         case (req_data.mode)
            lott_pkg::MODE_CONSTRUCT, lott_pkg::MODE_DESTRUCT: state_in = S_CMP;
            lott_pkg::MODE_REPORT:                             state_in = S_LOAD;
            default:                                           state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         empty_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         empty_ff     <= empty_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a finished report leaves no slot marked pending
   a_pending_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !any_pending)
      else $error("pending mark left after report");

   // a destruct finds a slot exactly when some slot matched
   a_destruct_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && !is_construct) |-> (found == hit_any))
      else $error("destruct pick disagrees with match");

   // slot addresses and tags only change in an update or a report
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      (ctl.commit || ctl.rotate) |-> (state_ff == S_UPD || state_ff == S_RPT))
      else $error("table written outside update or report");

   // rotation never overwrites a waiting leak word
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (step && head_occ) |-> out_free)
      else $error("leak word dropped");

endmodule

[hw/rtl/lott_cell.sv]
module lott_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  lott_pkg::cell_ctl_type     ctl,
   input  logic [lott_pkg::ADDR_W-1:0] req_address,
   input  logic [lott_pkg::TAG_W-1:0]  req_tag,
   input  lott_pkg::slot_type         nb_slot,
   output lott_pkg::slot_type         slot,
   input  logic                       pick_in,
   output logic                       pick_out,
   input  logic                       hit_in,
   output logic                       hit_out
);

   logic [lott_pkg::ADDR_W-1:0] address_ff, address_in;
   logic [lott_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic                        pending_ff, pending_in;
   logic                        match_ff, match_in;
   logic                        free_ff, free_in;
   logic                        cand;
   logic                        pick_here;

   // priority chain: the lowest candidate wins
   assign cand      = ctl.construct ? free_ff : match_ff;
   assign pick_here = cand & ~pick_in;
   assign pick_out  = pick_in | cand;
   assign hit_out   = hit_in | match_ff;

   assign slot.address = address_ff;
   assign slot.tag     = tag_ff;
   assign slot.pending = pending_ff;

   // flags against the held request
   always_comb begin
      match_in = match_ff;
      free_in  = free_ff;
      if (ctl.compare) begin
         match_in = (address_ff != '0) && (address_ff == req_address) && (tag_ff == req_tag);
         free_in  = (address_ff == '0);
      end
   end

   // slot contents
   always_comb begin
      address_in = address_ff;
      tag_in     = tag_ff;
      pending_in = pending_ff;
      if (ctl.rotate) begin
         address_in = nb_slot.address;
         tag_in     = nb_slot.tag;
         pending_in = nb_slot.pending;
      end else if (ctl.load) begin
         pending_in = (address_ff != '0);
      end else if (ctl.commit && pick_here) begin
         if (ctl.construct) begin
            address_in = req_address;
            tag_in     = req_tag;
         end else begin
            address_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= '0;
         pending_ff <= 1'b0;
         match_ff   <= 1'b0;
         free_ff    <= 1'b0;
      end else begin
         address_ff <= address_in;
         pending_ff <= pending_in;
         match_ff   <= match_in;
         free_ff    <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

endmodule
